[src/encoder_velocity_estimator_unit_macros.svh]
`ifndef ENCODER_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH
`define ENCODER_VELOCITY_ESTIMATOR_UNIT_MACROS_SVH

// Same-cycle implication check, clocked on clk, off during reset.
`define EVEST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("evest: same-cycle check failed");

// Next-cycle implication check, clocked on clk, off during reset.
`define EVEST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("evest: next-cycle check failed");

`endif

[src/evest_pkg.sv]
`timescale 1ns / 1ps

package evest_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int REG_W     = 32;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_FILTER_ALPHA  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_POSITION_UNIT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_VELOCITY_UNIT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REVS_PER_TICK = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WHEEL_CIRC    = 3'd4;

	localparam logic [1:0] UNIT_TICKS = 2'd0;
	localparam logic [1:0] UNIT_REVS  = 2'd1;
	localparam logic [1:0] UNIT_DEG   = 2'd2;
	localparam logic [1:0] UNIT_MM    = 2'd3;

	localparam logic [1:0] MODE_PAUSE   = 2'd0;
	localparam logic [1:0] MODE_CLEAR   = 2'd1;
	localparam logic [1:0] MODE_RUN     = 2'd2;
	localparam logic [1:0] MODE_RUN_ALT = 2'd3;

	localparam logic [2:0] OP_NUM     = 3'd0;
	localparam logic [2:0] OP_POS_REV = 3'd1;
	localparam logic [2:0] OP_POS_FIN = 3'd2;
	localparam logic [2:0] OP_VEL_REV = 3'd3;
	localparam logic [2:0] OP_VEL_FIN = 3'd4;

	localparam logic [16:0] ALPHA_ONE   = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd6554;
	localparam logic [31:0] RPT_RESET   = 32'd1073742;
	localparam logic [31:0] CIRC_RESET  = 32'd65536;

	localparam logic [31:0] US_PER_S   = 32'd1000000;
	localparam logic [31:0] RPM_FACTOR = 32'd60;
	localparam logic [31:0] DEG_FACTOR = 32'd360;

	localparam logic [47:0] POS_LIM = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] NEG_LIM = 48'h8000_0000_0000;

	typedef struct packed {
		logic       load;
		logic       mul_ld;
		logic [2:0] mul_op;
		logic       mul_lo;
		logic       mul_hi;
		logic       mul_acc;
		logic       div_load;
		logic       div_step;
		logic       filt1;
		logic       filt2;
		logic       take_pos;
		logic       take_vel;
		logic       out_load;
	} evest_cmd_t;

	typedef struct packed {
		logic zero_dt;
		logic pos_ticks;
		logic vel_ticks;
		logic div_last;
	} evest_sts_t;

	// Sign-magnitude to saturated 48-bit two's complement.
	function automatic logic [47:0] pack48(input logic neg, input logic big,
			input logic [47:0] mag);
		if (big)
			return neg ? NEG_LIM : POS_LIM;
		return neg ? (~mag + 48'd1) : mag;
	endfunction

endpackage

[src/evest_dp.sv]
`timescale 1ns / 1ps

module evest_dp import evest_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  evest_cmd_t           cmd,
	output evest_sts_t           sts,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic signed [31:0]   position,
	input  logic signed [31:0]   delta_position,
	input  logic [31:0]          interval_us,
	input  logic [1:0]           mode,
	output logic signed [47:0]   position_out,
	output logic signed [47:0]   velocity_out,
	output logic [47:0]          elapsed_us,
	output logic                 zero_interval
);

	localparam int DW  = 51 + FRAC_BITS;
	localparam int CW  = $clog2(DW + 1);
	localparam int PMW = 32 + FRAC_BITS;

	logic [16:0] alpha_q;
	logic [1:0]  pos_unit_q;
	logic [1:0]  vel_unit_q;
	logic [31:0] rpt_q;
	logic [31:0] circ_q;

	logic        p_neg_q;
	logic [31:0] p_mag_q;
	logic        d_neg_q;
	logic [31:0] d_mag_q;
	logic [31:0] dt_q;
	logic        zf_q;
	logic [47:0] rt_q;
	logic [47:0] fv_q;

	logic [63:0] mul_a_q;
	logic [31:0] mul_b_q;
	logic [63:0] pp_s1;
	logic [95:0] acc_q;

	logic [DW-1:0] dvd_q;
	logic [31:0]   rem_q;
	logic [46:0]   quo_q;
	logic          qovf_q;
	logic [CW-1:0] cnt_q;

	logic signed [67:0] filt_s1;
	logic [47:0]        pos_res_q;
	logic [47:0]        vel_res_q;

	logic [31:0]  p_mag_in;
	logic [31:0]  d_mag_in;
	logic [48:0]  rt_sum;
	logic [PMW-1:0] pmag_sh;
	logic [47:0]  v_mag;
	logic [63:0]  a_sel;
	logic [31:0]  b_sel;
	logic [31:0]  mul_half;
	logic [32:0]  rem_sh;
	logic         ge;
	logic [32:0]  rem_nx;
	logic [47:0]  raw_mag;
	logic signed [49:0] raw50;
	logic signed [49:0] diff;
	logic [16:0]  a_eff;
	logic [1:0]   take_unit;
	logic [95:0]  take_mag;
	logic [95:0]  take_val;
	logic         take_neg;
	logic [47:0]  take_res;

	assign p_mag_in = position[31] ? (~position + 32'd1) : position;
	assign d_mag_in = delta_position[31] ? (~delta_position + 32'd1) : delta_position;
	assign rt_sum   = {1'b0, rt_q} + {17'b0, interval_us};
	assign pmag_sh  = {p_mag_q, {FRAC_BITS{1'b0}}};
	assign v_mag    = fv_q[47] ? (~fv_q + 48'd1) : fv_q;

	assign sts.zero_dt   = (interval_us == 32'd0);
	assign sts.pos_ticks = (pos_unit_q == UNIT_TICKS);
	assign sts.vel_ticks = (vel_unit_q == UNIT_TICKS);
	assign sts.div_last  = (cnt_q == CW'(1));

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q    <= ALPHA_RESET;
			pos_unit_q <= UNIT_TICKS;
			vel_unit_q <= UNIT_TICKS;
			rpt_q      <= RPT_RESET;
			circ_q     <= CIRC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FILTER_ALPHA:  alpha_q    <= cfg_data[16:0];
				REG_POSITION_UNIT: pos_unit_q <= cfg_data[1:0];
				REG_VELOCITY_UNIT: vel_unit_q <= cfg_data[1:0];
				REG_REVS_PER_TICK: rpt_q      <= cfg_data;
				REG_WHEEL_CIRC:    circ_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// filter and run-time state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= '0;
			fv_q <= '0;
		end else begin
			if (cmd.load) begin
				if (mode == MODE_CLEAR)
					rt_q <= '0;
				else if (mode != MODE_PAUSE)
					rt_q <= rt_sum[48] ? '1 : rt_sum[47:0];
			end
			if (cmd.filt2)
				fv_q <= fv_q + filt_s1[63:16];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_neg_q <= position[31];
			p_mag_q <= p_mag_in;
			d_neg_q <= delta_position[31];
			d_mag_q <= d_mag_in;
			dt_q    <= interval_us;
			zf_q    <= (interval_us == 32'd0);
		end
	end

	// shared 32x32 multiplier, two partial products per operation
	always_comb begin
		case (cmd.mul_op)
			OP_NUM:     a_sel = {32'b0, d_mag_q};
			OP_POS_REV: a_sel = 64'(pmag_sh);
			OP_VEL_REV: a_sel = {16'b0, v_mag};
			OP_POS_FIN: a_sel = acc_q[95:32];
			OP_VEL_FIN: a_sel = acc_q[95:32];
			default:    a_sel = '0;
		endcase
		case (cmd.mul_op)
			OP_NUM:     b_sel = US_PER_S;
			OP_POS_REV: b_sel = rpt_q;
			OP_VEL_REV: b_sel = rpt_q;
			OP_POS_FIN: begin
				case (pos_unit_q)
					UNIT_REVS: b_sel = 32'd1;
					UNIT_DEG:  b_sel = DEG_FACTOR;
					default:   b_sel = circ_q;
				endcase
			end
			OP_VEL_FIN: begin
				case (vel_unit_q)
					UNIT_REVS: b_sel = RPM_FACTOR;
					UNIT_DEG:  b_sel = DEG_FACTOR;
					default:   b_sel = circ_q;
				endcase
			end
			default:    b_sel = '0;
		endcase
	end

	assign mul_half = cmd.mul_hi ? mul_a_q[63:32] : mul_a_q[31:0];

	always_ff @(posedge clk) begin
		if (cmd.mul_ld) begin
			mul_a_q <= a_sel;
			mul_b_q <= b_sel;
		end
		if (cmd.mul_lo || cmd.mul_hi)
			pp_s1 <= mul_half * mul_b_q;
		if (cmd.mul_hi)
			acc_q <= {32'b0, pp_s1};
		else if (cmd.mul_acc)
			acc_q <= acc_q + {pp_s1, 32'b0};
	end

	// restoring divider, one quotient bit per cycle
	assign rem_sh = {rem_q, dvd_q[DW-1]};
	assign ge     = (rem_sh >= {1'b0, dt_q});
	assign rem_nx = ge ? (rem_sh - {1'b0, dt_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_load) begin
			cnt_q <= CW'(DW);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			dvd_q  <= {acc_q[50:0], {FRAC_BITS{1'b0}}};
			rem_q  <= '0;
			quo_q  <= '0;
			qovf_q <= 1'b0;
		end else if (cmd.div_step) begin
			dvd_q  <= dvd_q << 1;
			rem_q  <= rem_nx[31:0];
			quo_q  <= {quo_q[45:0], ge};
			qovf_q <= qovf_q | quo_q[46];
		end
	end

	// exponential filter: v + (raw - v) * a / 2^16, floored
	assign raw_mag = qovf_q ? POS_LIM : {1'b0, quo_q};
	assign raw50   = d_neg_q ? -$signed({2'b0, raw_mag}) : $signed({2'b0, raw_mag});
	assign diff    = raw50 - $signed({{2{fv_q[47]}}, fv_q});
	assign a_eff   = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;

	always_ff @(posedge clk) begin
		if (cmd.filt1)
			filt_s1 <= diff * $signed({1'b0, a_eff});
	end

	// unit scaling result
	always_comb begin
		take_unit = cmd.take_vel ? vel_unit_q : pos_unit_q;
		take_neg  = cmd.take_vel ? fv_q[47] : p_neg_q;
		take_mag  = cmd.take_vel ? 96'(v_mag) : 96'(pmag_sh);
		case (take_unit)
			UNIT_TICKS: take_val = take_mag;
			UNIT_MM:    take_val = acc_q >> 16;
			default:    take_val = acc_q;
		endcase
		take_res = pack48(take_neg, |take_val[95:47], take_val[47:0]);
	end

	always_ff @(posedge clk) begin
		if (cmd.take_pos)
			pos_res_q <= take_res;
		if (cmd.take_vel)
			vel_res_q <= take_res;
		if (cmd.out_load) begin
			position_out  <= pos_res_q;
			velocity_out  <= vel_res_q;
			elapsed_us    <= rt_q;
			zero_interval <= zf_q;
		end
	end

endmodule

[src/evest_ctrl.sv]
`timescale 1ns / 1ps

module evest_ctrl import evest_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  evest_sts_t sts,
	output evest_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_DIVL  = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_FILT1 = 4'd4;
	localparam logic [3:0] S_FILT2 = 4'd5;
	localparam logic [3:0] S_TPOS  = 4'd6;
	localparam logic [3:0] S_TVEL  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q, state_d;
	logic [2:0] op_q, op_d;
	logic [1:0] ph_q, ph_d;
	logic       out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		op_d    = op_q;
		ph_d    = ph_q;
		cmd.mul_op = op_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.zero_dt) begin
						state_d = S_MUL;
						op_d    = OP_NUM;
						ph_d    = 2'd0;
					end else if (sts.pos_ticks) begin
						state_d = S_TPOS;
					end else begin
						state_d = S_MUL;
						op_d    = OP_POS_REV;
						ph_d    = 2'd0;
					end
				end
			end
			S_MUL: begin
				ph_d = ph_q + 2'd1;
				case (ph_q)
					2'd0: cmd.mul_ld = 1'b1;
					2'd1: cmd.mul_lo = 1'b1;
					2'd2: cmd.mul_hi = 1'b1;
					default: begin
						cmd.mul_acc = 1'b1;
						case (op_q)
							OP_NUM:     state_d = S_DIVL;
							OP_POS_REV: op_d = OP_POS_FIN;
							OP_POS_FIN: state_d = S_TPOS;
							OP_VEL_REV: op_d = OP_VEL_FIN;
							default:    state_d = S_TVEL;
						endcase
					end
				endcase
			end
			S_DIVL: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_FILT1;
			end
			S_FILT1: begin
				cmd.filt1 = 1'b1;
				state_d   = S_FILT2;
			end
			S_FILT2: begin
				cmd.filt2 = 1'b1;
				if (sts.pos_ticks) begin
					state_d = S_TPOS;
				end else begin
					state_d = S_MUL;
					op_d    = OP_POS_REV;
					ph_d    = 2'd0;
				end
			end
			S_TPOS: begin
				cmd.take_pos = 1'b1;
				if (sts.vel_ticks) begin
					state_d = S_TVEL;
				end else begin
					state_d = S_MUL;
					op_d    = OP_VEL_REV;
					ph_d    = 2'd0;
				end
			end
			S_TVEL: begin
				cmd.take_vel = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_NUM;
			ph_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			ph_q    <= ph_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

[src/encoder_velocity_estimator_unit.sv]
// Encoder velocity estimator: raw rate by serial division, EMA filter, unit scaling.
// A nonzero interval takes the restoring divider and the filter; a zero interval skips
// both. Each unit that is not ticks adds a scaling on the shared multiplier. Results
// are registered to the outputs, with out_valid, when the item ends.
// arst_n clears filter state, run time, control and loads register defaults.
`timescale 1ns / 1ps

`include "encoder_velocity_estimator_unit_macros.svh"

module encoder_velocity_estimator_unit import evest_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   position,
	input  logic signed [31:0]   delta_position,
	input  logic [31:0]          interval_us,
	input  logic [1:0]           mode,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [47:0]   position_out,
	output logic signed [47:0]   velocity_out,
	output logic [47:0]          elapsed_us,
	output logic                 zero_interval
);

	evest_cmd_t cmd;
	evest_sts_t sts;

	evest_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	evest_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.position       (position),
		.delta_position (delta_position),
		.interval_us    (interval_us),
		.mode           (mode),
		.position_out   (position_out),
		.velocity_out   (velocity_out),
		.elapsed_us     (elapsed_us),
		.zero_interval  (zero_interval)
	);

	`EVEST_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
	`EVEST_ASSERT_SAME(a_out_load_free, cmd.out_load, !out_valid || !out_stall)
	`EVEST_ASSERT_NEXT(a_out_after_take, cmd.take_vel, in_stall)

endmodule
